### rtl/stq_pkg.sv
package stq_pkg;

  typedef struct packed {
    logic idle;
    logic load;
    logic shift;
    logic put_new;
    logic pop;
    logic drop;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic req_valid;
    logic req_tick;
    logic full;
    logic rem_zero;
    logic later;
    logic due;
    logic obuf_free;
  } st_t;

endpackage

### rtl/stq_in_if.sv
interface stq_in_if #(
  parameter int TIME_BITS = 32,
  parameter int TAG_BITS  = 8
);
  logic                 valid;
  logic                 ready;
  logic                 func;
  logic [TIME_BITS-1:0] expire_at;
  logic [TAG_BITS-1:0]  event_tag;

  modport source (output valid, func, expire_at, event_tag, input ready);
  modport sink   (input valid, func, expire_at, event_tag, output ready);
endinterface

### rtl/stq_out_if.sv
interface stq_out_if #(
  parameter int TAG_BITS = 8,
  parameter int CNT_BITS = 5
);
  logic                valid;
  logic                ready;
  logic                fired;
  logic [TAG_BITS-1:0] fired_tag;
  logic                dropped;
  logic [CNT_BITS-1:0] pending_count;

  modport source (output valid, fired, fired_tag, dropped, pending_count, input ready);
  modport sink   (input valid, fired, fired_tag, dropped, pending_count, output ready);
endinterface

### rtl/stq_ctrl.sv
module stq_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  stq_pkg::st_t  st,
  output stq_pkg::cmd_t cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_INS  = 2'd1;
  localparam logic [1:0] S_TICK = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        cmd.idle = 1'b1;
        if (st.req_valid) begin
          cmd.load   = 1'b1;
          state_next = st.req_tick ? S_TICK : S_INS;
        end
      end
      S_INS: begin
        if (st.full) begin
          if (st.obuf_free) begin
            cmd.drop     = 1'b1;
            cmd.out_load = 1'b1;
            state_next   = S_IDLE;
          end
        end else if (st.rem_zero || !st.later) begin
          if (st.obuf_free) begin
            cmd.put_new  = 1'b1;
            cmd.out_load = 1'b1;
            state_next   = S_IDLE;
          end
        end else begin
          cmd.shift = 1'b1;
        end
      end
      S_TICK: begin
        if (st.obuf_free) begin
          cmd.pop      = st.due;
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

### rtl/stq_dp.sv
module stq_dp #(
  parameter int DEPTH     = 16,
  parameter int TIME_BITS = 32,
  parameter int TAG_BITS  = 8,
  parameter int CNT_W     = $clog2(DEPTH + 1)
) (
  input  logic          clk,
  input  logic          rst,
  stq_in_if.sink        req,
  stq_out_if.source     rsp,
  input  stq_pkg::cmd_t cmd,
  output stq_pkg::st_t  st
);

  localparam int IDX_W = $clog2(DEPTH);

  function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] a);
    return (a == IDX_W'(DEPTH - 1)) ? '0 : a + 1'b1;
  endfunction

  function automatic logic [IDX_W-1:0] wrap_dec(input logic [IDX_W-1:0] a);
    return (a == '0) ? IDX_W'(DEPTH - 1) : a - 1'b1;
  endfunction

  logic [TIME_BITS-1:0] mem_exp [DEPTH];
  logic [TAG_BITS-1:0]  mem_tag [DEPTH];

  logic [IDX_W-1:0]     head;
  logic [IDX_W-1:0]     tail;
  logic [IDX_W-1:0]     wp;
  logic [IDX_W-1:0]     wp_next;
  logic [IDX_W-1:0]     rd_addr;
  logic [CNT_W-1:0]     count;
  logic [CNT_W-1:0]     count_next;
  logic [CNT_W-1:0]     rem;
  logic [TIME_BITS-1:0] now;
  logic [TIME_BITS-1:0] when_r;
  logic [TAG_BITS-1:0]  tag_r;
  logic                 func_r;
  logic                 rd_sel_head;
  logic [TIME_BITS-1:0] rd_exp;
  logic [TAG_BITS-1:0]  rd_tag;

  assign req.ready = cmd.idle;

  assign wp_next     = cmd.load ? tail : (cmd.shift ? wrap_dec(wp) : wp);
  assign rd_sel_head = cmd.load ? req.func : func_r;
  assign rd_addr     = rd_sel_head ? head : wrap_dec(wp_next);

  always_comb begin
    count_next = count;
    if (cmd.put_new) begin
      count_next = count + 1'b1;
    end else if (cmd.pop) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.shift) begin
      mem_exp[wp] <= rd_exp;
      mem_tag[wp] <= rd_tag;
    end else if (cmd.put_new) begin
      mem_exp[wp] <= when_r;
      mem_tag[wp] <= tag_r;
    end
    rd_exp <= mem_exp[rd_addr];
    rd_tag <= mem_tag[rd_addr];
  end

  always_ff @(posedge clk) begin
    wp <= wp_next;
    if (cmd.load) begin
      func_r <= req.func;
      when_r <= req.expire_at;
      tag_r  <= req.event_tag;
      rem    <= count;
    end else if (cmd.shift) begin
      rem <= rem - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
      now   <= '0;
    end else begin
      count <= count_next;
      if (cmd.load && req.func) begin
        now <= now + 1'b1;
      end
      if (cmd.put_new) begin
        tail <= wrap_inc(tail);
      end
      if (cmd.pop) begin
        head <= wrap_inc(head);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (cmd.out_load) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      rsp.fired         <= cmd.pop;
      rsp.fired_tag     <= cmd.pop ? rd_tag : '0;
      rsp.dropped       <= cmd.drop;
      rsp.pending_count <= count_next;
    end
  end

  assign st.req_valid = req.valid;
  assign st.req_tick  = req.func;
  assign st.full      = (count == CNT_W'(DEPTH));
  assign st.rem_zero  = (rem == '0);
  assign st.later     = (rd_exp > when_r);
  assign st.due       = (count != '0) && (rd_exp <= now);
  assign st.obuf_free = !rsp.valid || rsp.ready;

endmodule

### rtl/sorted_timer_event_queue_unit.sv
// channel | role   | payload
// --------+--------+---------------------------------------------
// req     | sink   | func, expire_at, event_tag
// rsp     | source | fired, fired_tag, dropped, pending_count
//
// One rsp transaction per req transaction, in order.
// Add: the insertion walk moves each entry with a later expiry up one slot in
//   the one-read, one-write entry memory (at most QUEUE_DEPTH - 1 entries).
// Tick: one registered read of the head entry, then one compare.
// rst is synchronous; the entry memory is not cleared, the queue starts empty.
// A held rsp transaction stalls the finishing cycle of the next item only.
module sorted_timer_event_queue_unit #(
  parameter int QUEUE_DEPTH = 16,
  parameter int TIME_BITS   = 32,
  parameter int TAG_BITS    = 8
) (
  input logic clk,
  input logic rst,
  stq_in_if.sink    req,
  stq_out_if.source rsp
);

  localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

  stq_pkg::cmd_t cmd;
  stq_pkg::st_t  st;

  stq_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .st  (st),
    .cmd (cmd)
  );

  stq_dp #(
    .DEPTH     (QUEUE_DEPTH),
    .TIME_BITS (TIME_BITS),
    .TAG_BITS  (TAG_BITS),
    .CNT_W     (CNT_BITS)
  ) u_dp (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp),
    .cmd (cmd),
    .st  (st)
  );

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> st.obuf_free)
    else $error("result loaded while output register busy");

  a_shift_ok: assert property (@(posedge clk) disable iff (rst)
    cmd.shift |-> (!st.full && !st.rem_zero && st.later))
    else $error("insertion walk moved past its end");

  a_one_flag: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> !(rsp.fired && rsp.dropped))
    else $error("fired and dropped both set");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> (rsp.pending_count <= CNT_BITS'(QUEUE_DEPTH)))
    else $error("pending count beyond queue depth");

endmodule
